// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros : shared assertion wrappers
// clocked on clk, quiet while rst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every edge out of reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// implication checked at every edge out of reset
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: rtl/v3n_pkg.sv
// ----------------------------------------------------------------------------
// v3n_pkg : shared types for the vector normaliser
// widths and the payload records handed from cell to cell
// ----------------------------------------------------------------------------
`default_nettype none
package v3n_pkg;

  localparam int CompW   = 24;
  localparam int UnitW   = 18;
  localparam int LenW    = 24;
  localparam int SqW     = 48;
  localparam int QW      = 17;
  localparam int SqCells = SqW / 2;
  localparam int DivCells = QW;

  // one square-root cell record: partial remainder, partial root, radicand left
  typedef struct packed {
    logic              valid;
    logic [LenW+2:0]   rem;
    logic [LenW-1:0]   root;
    logic [SqW-1:0]    rad;
    logic [2:0]        neg;
    logic [CompW-1:0]  mag_x;
    logic [CompW-1:0]  mag_y;
    logic [CompW-1:0]  mag_z;
  } sq_t;

  // one divider cell record: three lanes sharing the same divisor
  typedef struct packed {
    logic              valid;
    logic [LenW-1:0]   len;
    logic [2:0]        neg;
    logic [LenW-1:0]   rem_x;
    logic [LenW-1:0]   rem_y;
    logic [LenW-1:0]   rem_z;
    logic [QW-1:0]     quo_x;
    logic [QW-1:0]     quo_y;
    logic [QW-1:0]     quo_z;
    logic [QW-1:0]     feed_x;
    logic [QW-1:0]     feed_y;
    logic [QW-1:0]     feed_z;
  } dv_t;

endpackage
`default_nettype wire

// File: rtl/v3n_sqrt_cell.sv
// ----------------------------------------------------------------------------
// v3n_sqrt_cell : one root bit of the digit-by-digit square root
// takes two radicand bits, tries (root<<2)|1 against the remainder
// ----------------------------------------------------------------------------
`default_nettype none
module v3n_sqrt_cell
  import v3n_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic en,
  input  wire sq_t  d_in,
  output sq_t       d_out
);

  sq_t              cell_r, cell_nxt;
  logic [LenW+2:0]  rem_sh;
  logic [LenW+2:0]  trial;

  always_comb begin
    rem_sh   = {d_in.rem[LenW:0], d_in.rad[SqW-1 -: 2]};
    trial    = {1'b0, d_in.root, 2'b01};
    cell_nxt = d_in;
    cell_nxt.rad = {d_in.rad[SqW-3:0], 2'b00};
    if (rem_sh >= trial) begin
      cell_nxt.rem  = rem_sh - trial;
      cell_nxt.root = {d_in.root[LenW-2:0], 1'b1};
    end else begin
      cell_nxt.rem  = rem_sh;
      cell_nxt.root = {d_in.root[LenW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.valid <= 1'b0;
    end else if (en) begin
      cell_r <= cell_nxt;
    end
  end

  assign d_out = cell_r;

endmodule
`default_nettype wire

// File: rtl/v3n_div_cell.sv
// ----------------------------------------------------------------------------
// v3n_div_cell : one quotient bit of restoring division, three lanes
// each lane shifts in one dividend bit and subtracts the length if it fits
// ----------------------------------------------------------------------------
`default_nettype none
module v3n_div_cell
  import v3n_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic en,
  input  wire dv_t  d_in,
  output dv_t       d_out
);

  dv_t           cell_r, cell_nxt;
  logic [LenW:0] rs_x, rs_y, rs_z;
  logic [LenW:0] dsr;

  always_comb begin
    dsr  = {1'b0, d_in.len};
    rs_x = {d_in.rem_x, d_in.feed_x[QW-1]};
    rs_y = {d_in.rem_y, d_in.feed_y[QW-1]};
    rs_z = {d_in.rem_z, d_in.feed_z[QW-1]};
    cell_nxt = d_in;
    cell_nxt.feed_x = {d_in.feed_x[QW-2:0], 1'b0};
    cell_nxt.feed_y = {d_in.feed_y[QW-2:0], 1'b0};
    cell_nxt.feed_z = {d_in.feed_z[QW-2:0], 1'b0};
    if (rs_x >= dsr) begin
      cell_nxt.rem_x = LenW'(rs_x - dsr);
      cell_nxt.quo_x = {d_in.quo_x[QW-2:0], 1'b1};
    end else begin
      cell_nxt.rem_x = rs_x[LenW-1:0];
      cell_nxt.quo_x = {d_in.quo_x[QW-2:0], 1'b0};
    end
    if (rs_y >= dsr) begin
      cell_nxt.rem_y = LenW'(rs_y - dsr);
      cell_nxt.quo_y = {d_in.quo_y[QW-2:0], 1'b1};
    end else begin
      cell_nxt.rem_y = rs_y[LenW-1:0];
      cell_nxt.quo_y = {d_in.quo_y[QW-2:0], 1'b0};
    end
    if (rs_z >= dsr) begin
      cell_nxt.rem_z = LenW'(rs_z - dsr);
      cell_nxt.quo_z = {d_in.quo_z[QW-2:0], 1'b1};
    end else begin
      cell_nxt.rem_z = rs_z[LenW-1:0];
      cell_nxt.quo_z = {d_in.quo_z[QW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.valid <= 1'b0;
    end else if (en) begin
      cell_r <= cell_nxt;
    end
  end

  assign d_out = cell_r;

endmodule
`default_nettype wire

// File: rtl/vector3_normalize.sv
// registers from input transaction to result: 3 front stages,
//   24 square-root cells, 17 divider cells, 1 output register
// throughput: one vector per cycle; the chain of cells stalls as a whole
//   only while a result sits unaccepted in the output register
// reset: synchronous active-low rst_n clears every valid bit; no other state
// ----------------------------------------------------------------------------
// vector3_normalize : fixed-point 3-vector normaliser
// squares and sums, floor square root, then divides each component by it
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module vector3_normalize
  import v3n_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [71:0] in_tdata,   // comp_x, comp_y, comp_z
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [79:0]      out_tdata,  // unit_x, unit_y, unit_z, vec_length, pad
  output logic             out_tuser   // zero_vector
);

  logic en;

  // front: magnitudes, squares, sum
  logic             f1_valid_r;
  logic [2:0]       f1_neg_r;
  logic [CompW-1:0] f1_mx_r, f1_my_r, f1_mz_r;
  logic             f2_valid_r;
  logic [2:0]       f2_neg_r;
  logic [CompW-1:0] f2_mx_r, f2_my_r, f2_mz_r;
  logic [SqW-1:0]   f2_sx_r, f2_sy_r, f2_sz_r;
  sq_t              sq_head_r;

  logic [CompW-1:0] cx, cy, cz;

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  assign cx = in_tdata[23:0];
  assign cy = in_tdata[47:24];
  assign cz = in_tdata[71:48];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_valid_r      <= 1'b0;
      f2_valid_r      <= 1'b0;
      sq_head_r.valid <= 1'b0;
    end else if (en) begin
      f1_valid_r <= in_tvalid;
      f1_neg_r   <= {cz[CompW-1], cy[CompW-1], cx[CompW-1]};
      f1_mx_r    <= cx[CompW-1] ? (~cx + 1'b1) : cx;
      f1_my_r    <= cy[CompW-1] ? (~cy + 1'b1) : cy;
      f1_mz_r    <= cz[CompW-1] ? (~cz + 1'b1) : cz;

      f2_valid_r <= f1_valid_r;
      f2_neg_r   <= f1_neg_r;
      f2_mx_r    <= f1_mx_r;
      f2_my_r    <= f1_my_r;
      f2_mz_r    <= f1_mz_r;
      f2_sx_r    <= f1_mx_r * f1_mx_r;
      f2_sy_r    <= f1_my_r * f1_my_r;
      f2_sz_r    <= f1_mz_r * f1_mz_r;

      sq_head_r.valid <= f2_valid_r;
      sq_head_r.rem   <= '0;
      sq_head_r.root  <= '0;
      sq_head_r.rad   <= f2_sx_r + f2_sy_r + f2_sz_r;
      sq_head_r.neg   <= f2_neg_r;
      sq_head_r.mag_x <= f2_mx_r;
      sq_head_r.mag_y <= f2_my_r;
      sq_head_r.mag_z <= f2_mz_r;
    end
  end

  // square-root chain
  sq_t sq_link [SqCells+1];
  assign sq_link[0] = sq_head_r;

  for (genvar i = 0; i < SqCells; i++) begin : g_sqrt
    v3n_sqrt_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .d_in  (sq_link[i]),
      .d_out (sq_link[i+1])
    );
  end

  // divider chain: start remainder is mag>>1, remaining dividend bits {mag[0], 16 zeros}
  dv_t dv_link [DivCells+1];
  sq_t sq_tail;
  assign sq_tail = sq_link[SqCells];

  always_comb begin
    dv_link[0].valid  = sq_tail.valid;
    dv_link[0].len    = sq_tail.root;
    dv_link[0].neg    = sq_tail.neg;
    dv_link[0].rem_x  = {1'b0, sq_tail.mag_x[CompW-1:1]};
    dv_link[0].rem_y  = {1'b0, sq_tail.mag_y[CompW-1:1]};
    dv_link[0].rem_z  = {1'b0, sq_tail.mag_z[CompW-1:1]};
    dv_link[0].quo_x  = '0;
    dv_link[0].quo_y  = '0;
    dv_link[0].quo_z  = '0;
    dv_link[0].feed_x = {sq_tail.mag_x[0], {(QW-1){1'b0}}};
    dv_link[0].feed_y = {sq_tail.mag_y[0], {(QW-1){1'b0}}};
    dv_link[0].feed_z = {sq_tail.mag_z[0], {(QW-1){1'b0}}};
  end

  for (genvar j = 0; j < DivCells; j++) begin : g_div
    v3n_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .d_in  (dv_link[j]),
      .d_out (dv_link[j+1])
    );
  end

  // output register with sign restore
  dv_t             dv_tail;
  logic            zero_nxt;
  logic [UnitW-1:0] ux_nxt, uy_nxt, uz_nxt;
  logic            out_valid_r;
  logic [UnitW-1:0] ux_r, uy_r, uz_r;
  logic [LenW-1:0] len_r;
  logic            zero_r;

  assign dv_tail  = dv_link[DivCells];
  assign zero_nxt = (dv_tail.len == '0);

  always_comb begin
    ux_nxt = {1'b0, dv_tail.quo_x};
    uy_nxt = {1'b0, dv_tail.quo_y};
    uz_nxt = {1'b0, dv_tail.quo_z};
    if (dv_tail.neg[0]) ux_nxt = ~ux_nxt + 1'b1;
    if (dv_tail.neg[1]) uy_nxt = ~uy_nxt + 1'b1;
    if (dv_tail.neg[2]) uz_nxt = ~uz_nxt + 1'b1;
    if (zero_nxt) begin
      ux_nxt = '0;
      uy_nxt = '0;
      uz_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_tail.valid;
      ux_r        <= ux_nxt;
      uy_r        <= uy_nxt;
      uz_r        <= uz_nxt;
      len_r       <= dv_tail.len;
      zero_r      <= zero_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, len_r, uz_r, uy_r, ux_r};
  assign out_tuser  = zero_r;

  `ASSERT_IMPL(a_zero_len, out_tvalid && out_tuser, len_r == '0 && ux_r == '0, "zero data")
  `ASSERT_IMPL(a_len_flag, out_tvalid && !out_tuser, len_r != '0, "zero length unflagged")
  `ASSERT_CLK(a_stall, in_tready || (out_tvalid && !out_tready), "stall without backpressure")

endmodule
`default_nettype wire
